// ===== hdl/lzwd_pkg.sv =====
`timescale 1ns / 1ps

package lzwd_pkg;

  // Field widths of the token and result channels
  localparam int BYTE_W       = 8;
  localparam int OFFSET_W     = 8;
  localparam int LEN_W        = 6;
  localparam int OFFSET_CODES = 1 << OFFSET_W;

  // Token sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_LIT
  } state_t;

  // Per-cycle command from the sequencer to the cell chain and output register
  typedef struct packed {
    logic emit;         // one byte leaves this cycle and shifts into the chain
    logic use_literal;  // the byte is the token literal, not a window tap
    logic last;         // final byte of the token
  } ctrl_t;

endpackage

// ===== hdl/lz77_window_decoder.sv =====
`timescale 1ns / 1ps
// Path: the first byte of a token passes the sequencer state register and then the
// output register to out_byte. Bytes of a token leave one byte per cycle while the
// output register is not stalled, set by the single shift per cycle of the window
// cell chain; a new request is taken only after the last byte of a token is emitted.
// Reset: synchronous active-low rst_n clears every window cell to zero, the
// sequencer and the output valid; the next token is taken as a raw literal.
module lz77_window_decoder #(
  parameter int WINDOW     = 8,
  parameter int MAX_LENGTH = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lzwd_pkg::OFFSET_W-1:0] in_match_offset,
  input  logic [lzwd_pkg::LEN_W-1:0]    in_match_length,
  input  logic [lzwd_pkg::BYTE_W-1:0]   in_literal_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lzwd_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last
);

  localparam int IDX_W = $clog2(WINDOW);

  lzwd_pkg::ctrl_t             ctrl;
  logic [IDX_W-1:0]            tap_idx;
  logic [lzwd_pkg::BYTE_W-1:0] literal;
  logic [lzwd_pkg::BYTE_W-1:0] emit_byte;
  logic [lzwd_pkg::BYTE_W-1:0] cell_q [WINDOW];
  logic                        can_emit;
  logic                        out_valid_r;
  logic [lzwd_pkg::BYTE_W-1:0] out_byte_r;
  logic                        out_last_r;

  // Room in the output register
  assign can_emit = !out_valid_r || !out_stall;

  lzwd_ctrl #(
    .WINDOW     (WINDOW),
    .MAX_LENGTH (MAX_LENGTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_match_offset (in_match_offset),
    .in_match_length (in_match_length),
    .in_literal_byte (in_literal_byte),
    .can_emit        (can_emit),
    .ctrl            (ctrl),
    .tap_idx         (tap_idx),
    .literal         (literal)
  );

  // Pick the literal or the window tap
  assign emit_byte = ctrl.use_literal ? literal : cell_q[tap_idx];

  // Window chain: the newest byte enters cell 0, each cell passes its byte on
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      lzwd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ctrl.emit),
        .d_in     (emit_byte),
        .q        (cell_q[i])
      );
    end else begin : g_body
      lzwd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ctrl.emit),
        .d_in     (cell_q[i-1]),
        .q        (cell_q[i])
      );
    end
  end

  // Output register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_emit) begin
      out_valid_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= ctrl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // Never emit into a full, stalled output register
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> can_emit)
    else $error("byte emitted while output register is held");

  // A request is taken only while no token is being emitted
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !ctrl.emit)
    else $error("request accepted during emission");

  // After the last byte of a token the sequencer is ready again
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit && ctrl.last) |=> !in_stall)
    else $error("sequencer still busy after last byte");

  // Every emitted byte enters the head of the window
  a_head_write: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |=> (cell_q[0] == $past(emit_byte)))
    else $error("emitted byte missing from window head");

  // The output register carries what was emitted
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |=> (out_valid && (out_byte == $past(emit_byte))
                   && (out_last == $past(ctrl.last))))
    else $error("output register does not match emitted byte");

endmodule

// ===== hdl/lzwd_cell.sv =====
`timescale 1ns / 1ps

module lzwd_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic [lzwd_pkg::BYTE_W-1:0] d_in,
  output logic [lzwd_pkg::BYTE_W-1:0] q
);

  logic [lzwd_pkg::BYTE_W-1:0] data_r;

  // Hold one window byte; take the neighbor's byte on each shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else if (shift_en) begin
      data_r <= d_in;
    end
  end

  assign q = data_r;

endmodule

// ===== hdl/lzwd_ctrl.sv =====
`timescale 1ns / 1ps

module lzwd_ctrl #(
  parameter int WINDOW     = 8,
  parameter int MAX_LENGTH = 63,
  parameter int IDX_W      = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lzwd_pkg::OFFSET_W-1:0] in_match_offset,
  input  logic [lzwd_pkg::LEN_W-1:0]    in_match_length,
  input  logic [lzwd_pkg::BYTE_W-1:0]   in_literal_byte,
  input  logic                         can_emit,
  output lzwd_pkg::ctrl_t              ctrl,
  output logic [IDX_W-1:0]             tap_idx,
  output logic [lzwd_pkg::BYTE_W-1:0]   literal
);

  lzwd_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]            tap_r, tap_nxt;
  logic [lzwd_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [lzwd_pkg::BYTE_W-1:0] lit_r, lit_nxt;
  logic                        first_done_r, first_done_nxt;
  logic [lzwd_pkg::LEN_W-1:0]  len_sat;
  logic                        accept;

  // Map each offset code to its tap: offset k reads cell (k mod WINDOW)-1,
  // and an offset that is a multiple of WINDOW reads the oldest cell
  logic [IDX_W-1:0] tap_tbl [lzwd_pkg::OFFSET_CODES];

  for (genvar g = 0; g < lzwd_pkg::OFFSET_CODES; g++) begin : g_tap
    assign tap_tbl[g] = ((g % WINDOW) == 0) ? IDX_W'(WINDOW - 1)
                                            : IDX_W'((g % WINDOW) - 1);
  end

  // Clamp the copy length
  assign len_sat = (in_match_length > lzwd_pkg::LEN_W'(MAX_LENGTH))
                 ? lzwd_pkg::LEN_W'(MAX_LENGTH) : in_match_length;
  assign accept  = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzwd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (first_done_r && (len_sat != '0)) ? lzwd_pkg::ST_COPY
                                                       : lzwd_pkg::ST_LIT;
        end
      end
      lzwd_pkg::ST_COPY: begin
        if (can_emit && (cnt_r == lzwd_pkg::LEN_W'(1))) begin
          state_nxt = lzwd_pkg::ST_LIT;
        end
      end
      lzwd_pkg::ST_LIT: begin
        if (can_emit) begin
          state_nxt = lzwd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lzwd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall         = (state_r != lzwd_pkg::ST_IDLE);
    ctrl.emit        = (state_r != lzwd_pkg::ST_IDLE) && can_emit;
    ctrl.use_literal = (state_r == lzwd_pkg::ST_LIT);
    ctrl.last        = (state_r == lzwd_pkg::ST_LIT);
  end

  // Token registers: latch on request, count down the copy
  always_comb begin
    tap_nxt        = tap_r;
    cnt_nxt        = cnt_r;
    lit_nxt        = lit_r;
    first_done_nxt = first_done_r;
    if (accept) begin
      tap_nxt = tap_tbl[in_match_offset];
      cnt_nxt = len_sat;
      lit_nxt = in_literal_byte;
    end
    if (ctrl.emit && (state_r == lzwd_pkg::ST_COPY)) begin
      cnt_nxt = cnt_r - lzwd_pkg::LEN_W'(1);
    end
    if (ctrl.emit && (state_r == lzwd_pkg::ST_LIT)) begin
      first_done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lzwd_pkg::ST_IDLE;
      first_done_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_done_r <= first_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tap_r <= tap_nxt;
    cnt_r <= cnt_nxt;
    lit_r <= lit_nxt;
  end

  assign tap_idx = tap_r;
  assign literal = lit_r;

endmodule

// ===== tb/lz77_window_decoder_checker.sv =====
`timescale 1ns / 1ps

module lz77_window_decoder_checker #(
  parameter int WINDOW     = 8,
  parameter int MAX_LENGTH = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [lzwd_pkg::OFFSET_W-1:0] in_match_offset,
  input  logic [lzwd_pkg::LEN_W-1:0]    in_match_length,
  input  logic [lzwd_pkg::BYTE_W-1:0]   in_literal_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [lzwd_pkg::BYTE_W-1:0]   out_byte,
  input  logic                          out_last,
  output int                            err_count,
  output int                            pending,
  output int                            bytes_checked
);

  typedef struct packed {
    logic [lzwd_pkg::BYTE_W-1:0] data;
    logic                        last;
  } decoded_byte_t;

  // Shadow copy of the history ring and its write pointer
  logic [lzwd_pkg::BYTE_W-1:0] history [WINDOW];
  int                          wr_slot;
  bit                          seen_first;
  decoded_byte_t               expected_bytes [$];

  int errs    = 0;
  int waiting = 0;
  int checked = 0;

  assign err_count     = errs;
  assign pending       = waiting;
  assign bytes_checked = checked;

  // Emit one byte: queue it and shift it into the ring
  task automatic emit_byte(input logic [lzwd_pkg::BYTE_W-1:0] data, input logic last);
    decoded_byte_t b;
    b.data = data;
    b.last = last;
    expected_bytes = {expected_bytes, b};
    history[wr_slot] = data;
    wr_slot = (wr_slot + 1) % WINDOW;
  endtask

  // Expand one token into the bytes it produces
  task automatic decode_token(input logic [lzwd_pkg::OFFSET_W-1:0] offset,
                              input logic [lzwd_pkg::LEN_W-1:0]    length,
                              input logic [lzwd_pkg::BYTE_W-1:0]   literal);
    int span;
    int count;
    span  = int'(offset) % WINDOW;
    count = (int'(length) > MAX_LENGTH) ? MAX_LENGTH : int'(length);
    // first token after reset is a bare literal
    if (!seen_first) begin
      seen_first = 1'b1;
      emit_byte(literal, 1'b1);
      return;
    end
    // copy one byte at a time so overlapping runs read fresh bytes
    for (int j = 0; j < count; j++) begin
      emit_byte(history[(wr_slot + WINDOW - span) % WINDOW], 1'b0);
    end
    emit_byte(literal, 1'b1);
  endtask

  always @(posedge clk) begin
    decoded_byte_t exp_b;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) history[i] = '0;
      wr_slot    = 0;
      seen_first = 1'b0;
      expected_bytes.delete();
    end else begin
      // check a delivered byte against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: out_byte=%02h out_last=%0b", out_byte, out_last);
          errs++;
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_byte !== exp_b.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", exp_b.data, out_byte);
            errs++;
          end
          if (out_last !== exp_b.last) begin
            $error("out_last mismatch: expected %0b, actual %0b", exp_b.last, out_last);
            errs++;
          end
          checked++;
        end
      end
      // predict the bytes of an accepted request
      if (in_valid && !in_stall) begin
        decode_token(in_match_offset, in_match_length, in_literal_byte);
      end
    end
    waiting = expected_bytes.size();
  end

endmodule

// ===== tb/lz77_window_decoder_tb.sv =====
`timescale 1ns / 1ps

module lz77_window_decoder_tb;

  localparam int WINDOW      = 8;
  localparam int MAX_LENGTH  = 63;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [lzwd_pkg::OFFSET_W-1:0] in_match_offset = '0;
  logic [lzwd_pkg::LEN_W-1:0]    in_match_length = '0;
  logic [lzwd_pkg::BYTE_W-1:0]   in_literal_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [lzwd_pkg::BYTE_W-1:0]   out_byte;
  logic out_last;

  int err_count;
  int pending;
  int bytes_checked;

  int snd_idle_pct = 18;
  int rcv_idle_pct = 74;
  int hold_req     = 0;
  int tokens_sent  = 0;
  int cycles       = 0;

  lz77_window_decoder #(
    .WINDOW    (WINDOW),
    .MAX_LENGTH(MAX_LENGTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_match_offset(in_match_offset),
    .in_match_length(in_match_length),
    .in_literal_byte(in_literal_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

  lz77_window_decoder_checker #(
    .WINDOW    (WINDOW),
    .MAX_LENGTH(MAX_LENGTH)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_match_offset(in_match_offset),
    .in_match_length(in_match_length),
    .in_literal_byte(in_literal_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .err_count      (err_count),
    .pending        (pending),
    .bytes_checked  (bytes_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Offer one request and hold it until accepted; call and return at a falling edge
  task automatic send_token(input logic [lzwd_pkg::OFFSET_W-1:0] offset,
                            input logic [lzwd_pkg::LEN_W-1:0]    length,
                            input logic [lzwd_pkg::BYTE_W-1:0]   literal);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_match_offset <= offset;
    in_match_length <= length;
    in_literal_byte <= literal;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokens_sent++;
    @(negedge clk);
  endtask

  // Random tokens, mostly short matches with an occasional long one
  task automatic send_random(input int count);
    int r;
    logic [lzwd_pkg::LEN_W-1:0] length;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 65) length = lzwd_pkg::LEN_W'($urandom_range(7));
      else if (r < 90) length = lzwd_pkg::LEN_W'($urandom_range(20, 8));
      else length = lzwd_pkg::LEN_W'($urandom_range(63, 21));
      send_token(lzwd_pkg::OFFSET_W'($urandom_range(255)), length,
                 lzwd_pkg::BYTE_W'($urandom_range(255)));
    end
  endtask

  // Drop valid and wait for every predicted byte to drain
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // first token: offset and length ignored, literal alone
    send_token(8'hff, 6'h3f, 8'ha5);
    // early reads from the cleared ring, zero offset on the fresh ring
    send_token(8'h00, 6'd3, 8'h5a);
    send_token(8'h05, 6'd4, 8'h00);
    // literal only
    send_token(8'h03, 6'd0, 8'hff);
    // overlapping run at distance one and two
    send_token(8'h01, 6'd10, 8'h11);
    send_token(8'h02, 6'd7, 8'h22);
    // full-window distance, and offsets that wrap modulo the window
    send_token(8'h07, 6'd5, 8'h80);
    send_token(8'hff, 6'd6, 8'h7f);
    send_token(8'h08, 6'd2, 8'h55);
    send_token(8'h80, 6'd1, 8'haa);
    send_token(8'h55, 6'h15, 8'h33);
    send_token(8'haa, 6'h2a, 8'hcc);
    send_token(8'h10, 6'd3, 8'h01);
    // maximum length, with zero offset and with a large one
    send_token(8'h00, 6'h3f, 8'hfe);
    send_token(8'hf9, 6'h3f, 8'h40);
    send_token(8'h04, 6'h20, 8'h02);
    send_token(8'h06, 6'd1, 8'h04);
    send_token(8'h40, 6'd8, 8'h08);
    send_token(8'h20, 6'd9, 8'h10);
    send_token(8'h02, 6'd0, 8'h20);

    // sender mostly busy, receiver heavily stalled
    send_random(84);
    drain();

    // sender heavily idle, receiver mostly ready
    snd_idle_pct = 74;
    rcv_idle_pct = 18;
    send_random(84);
    drain();

    // full rate, opened by a long output hold-off while requests keep coming
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req++;
    send_random(84);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Decoded %0d tokens into %0d checked bytes over three idle mixes,",
             tokens_sent, bytes_checked);
    $display("including a %0d-cycle output hold-off and full drains between phases.",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
